/* rtl/chrg_pkg.sv */
// ----------------------------------------------------------------------------
// chrg_pkg - shared types and constants of the counter hash random generator
// Holds the mode codes, mixing constants and the job record passed from the
// front end to the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package chrg_pkg;

  localparam int unsigned ModeW = 3;
  localparam int unsigned IdW   = 64;
  localparam int unsigned WordW = 32;

  localparam logic [ModeW-1:0] ModeKeyVal = 3'd0;
  localparam logic [ModeW-1:0] ModeKeyMod = 3'd1;
  localparam logic [ModeW-1:0] ModeKeyVec = 3'd2;
  localparam logic [ModeW-1:0] ModeCntVal = 3'd3;
  localparam logic [ModeW-1:0] ModeCntVec = 3'd4;

  localparam logic [WordW-1:0] MixC1   = 32'hcc9e2d51;
  localparam logic [WordW-1:0] MixC2   = 32'h1b873593;
  localparam logic [WordW-1:0] MixAdd  = 32'he6546b64;
  localparam logic [WordW-1:0] FinM1   = 32'h85ebca6b;
  localparam logic [WordW-1:0] FinM2   = 32'hc2b2ae35;
  localparam logic [IdW-1:0]   VecOfsY = 64'd8932114;
  localparam logic [IdW-1:0]   VecOfsZ = 64'd90191230;
  localparam logic [WordW-1:0] SignFlip = 32'h80000000;

  localparam int unsigned QueueDepth = 4;

  // one hash job: identifier plus what the result needs
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [WordW-1:0] modulus;
    logic             do_mod;
    logic             last;
  } job_t;

endpackage

`default_nettype wire

/* rtl/counter_hash_random_generator.sv */
// ----------------------------------------------------------------------------
// counter_hash_random_generator - seeded hash random source
// Requests arrive on the s_axis group: tdata packs mode[2:0], unique_id[66:3],
// modulus[98:67]. Results leave on m_axis: tdata packs raw_hash[31:0],
// remainder[63:32], signed_unit[95:64], divide_by_zero[96]; tlast marks the
// final result of a request (vec3 modes give three results, others one,
// undefined modes none). The user must write the seed through hash_seed_we_i
// and hash_seed_i only while idle; the block does not enforce this.
// A front end expands each request into hash jobs and owns the draw counter;
// a four-entry queue decouples it from the hash engine. The engine computes
// each value through one shared 32x32 multiplier, then a bit-serial division
// in modulo mode, then the output handshake; it takes a new job only after
// the result has left.
// A stalled receiver holds the result; the queue then fills and s_axis_tready
// drops. Reset clears the seed and draw counter and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_hash_random_generator #(
  parameter int unsigned QueueDepth = chrg_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          hash_seed_we_i,
  input  wire logic [31:0]   hash_seed_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [103:0]  s_axis_tdata,  // mode, unique_id, modulus
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [103:0]       m_axis_tdata,  // raw_hash, remainder, signed_unit, dbz
  output logic               m_axis_tlast
);
  import chrg_pkg::*;

  logic [31:0] seed_q;
  logic        fj_valid, fj_ready, qj_valid, qj_ready;
  job_t        fj, qj;
  logic [31:0] raw, rem, su;
  logic        dbz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (hash_seed_we_i) begin
      seed_q <= hash_seed_i;
    end
  end

  chrg_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tdata[2:0]),
    .id_i       (s_axis_tdata[66:3]),
    .modulus_i  (s_axis_tdata[98:67]),
    .job_valid_o(fj_valid),
    .job_ready_i(fj_ready),
    .job_o      (fj)
  );

  chrg_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(fj_valid),
    .push_ready_o(fj_ready),
    .push_data_i (fj),
    .pop_valid_o (qj_valid),
    .pop_ready_i (qj_ready),
    .pop_data_o  (qj)
  );

  chrg_hash u_hash (
    .clk_i, .rst_ni,
    .seed_i       (seed_q),
    .job_valid_i  (qj_valid),
    .job_ready_o  (qj_ready),
    .job_i        (qj),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .raw_hash_o   (raw),
    .remainder_o  (rem),
    .signed_unit_o(su),
    .last_o       (m_axis_tlast),
    .dbz_o        (dbz)
  );

  assign m_axis_tdata = {7'd0, dbz, su, rem, raw};

endmodule

`default_nettype wire

/* rtl/chrg_front.sv */
// ----------------------------------------------------------------------------
// chrg_front - accepts requests and expands them into hash jobs
// Decodes the mode, owns the draw counter and issues one job per cycle while the queue accepts.
// ----------------------------------------------------------------------------
`default_nettype none

module chrg_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [2:0]           mode_i,
  input  wire logic [63:0]          id_i,
  input  wire logic [31:0]          modulus_i,
  output logic                      job_valid_o,
  input  wire logic                 job_ready_i,
  output chrg_pkg::job_t            job_o
);
  import chrg_pkg::*;

  logic [WordW-1:0] cnt_q, cnt_d;
  logic [1:0]       idx_q, idx_d;
  logic             busy_q, busy_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [WordW-1:0] mod_q, mod_d;
  logic             vec, valid_mode, issue;
  logic [IdW-1:0]   base;

  assign in_ready_o  = !busy_q;
  assign job_valid_o = busy_q;
  assign issue       = busy_q && job_ready_i;
  assign vec         = (mode_q == ModeKeyVec) || (mode_q == ModeCntVec);
  assign valid_mode  = (mode_i == ModeKeyVal) || (mode_i == ModeKeyMod) ||
                       (mode_i == ModeKeyVec) || (mode_i == ModeCntVal) ||
                       (mode_i == ModeCntVec);

  always_comb begin
    base = id_q;
    if (mode_q == ModeCntVal || mode_q == ModeCntVec) begin
      base = {32'd0, cnt_q};
    end
    job_o.id = base;
    if (idx_q == 2'd1) begin
      job_o.id = (mode_q == ModeCntVec) ? {32'd0, cnt_q} : id_q + VecOfsY;
    end else if (idx_q == 2'd2) begin
      job_o.id = (mode_q == ModeCntVec) ? {32'd0, cnt_q} : id_q + VecOfsZ;
    end
    job_o.modulus = mod_q;
    job_o.do_mod  = (mode_q == ModeKeyMod);
    job_o.last    = !vec || (idx_q == 2'd2);
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    id_d   = id_q;
    mod_d  = mod_q;
    if (in_valid_i && in_ready_o && valid_mode) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
      mode_d = mode_i;
      id_d   = id_i;
      mod_d  = modulus_i;
    end else if (issue) begin
      // counter advances once per drawn value
      if (mode_q == ModeCntVal || mode_q == ModeCntVec) begin
        cnt_d = cnt_q + 32'd1;
      end
      if (job_o.last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    id_q   <= id_d;
    mod_q  <= mod_d;
  end

endmodule

`default_nettype wire

/* rtl/chrg_queue.sv */
// ----------------------------------------------------------------------------
// chrg_queue - small job queue between front end and hash engine
// Register-based FIFO with independent push and pop handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module chrg_queue #(
  parameter int unsigned Depth = chrg_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire chrg_pkg::job_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output chrg_pkg::job_t      pop_data_o
);
  import chrg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != Depth[PtrW:0]);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/chrg_hash.sv */
// ----------------------------------------------------------------------------
// chrg_hash - hash engine with optional modulo reduction
// Runs the two block rounds and the final mix as a multi-cycle sequence with
// one shared 32x32 multiplier, then a bit-serial remainder when asked for.
// ----------------------------------------------------------------------------
`default_nettype none

module chrg_hash (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [31:0]    seed_i,
  input  wire logic           job_valid_i,
  output logic                job_ready_o,
  input  wire chrg_pkg::job_t job_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output logic [31:0]         raw_hash_o,
  output logic [31:0]         remainder_o,
  output logic [31:0]         signed_unit_o,
  output logic                last_o,
  output logic                dbz_o
);
  import chrg_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StW0a, StW0b, StW1a, StW1b, StF1, StF2, StDiv, StOut
  } state_e;

  state_e           state_q;
  logic [WordW-1:0] h_q, w_q, hi_q, mod_q, rem_q, quo_q;
  logic [5:0]       bit_q;
  logic             do_mod_q, last_q, dbz_q;
  logic [WordW-1:0] mul_a, mul_b, prod, wr, hx, f1;
  logic [WordW:0]   trial;

  assign mul_a = (state_q == StF1 || state_q == StF2) ? h_q : w_q;
  always_comb begin
    case (state_q)
      StW0a, StW1a: mul_b = MixC1;
      StW0b, StW1b: mul_b = MixC2;
      StF1:         mul_b = FinM1;
      default:      mul_b = FinM2;
    endcase
  end
  assign prod  = mul_a * mul_b;
  assign wr    = {prod[16:0], prod[31:17]};
  assign hx    = h_q ^ prod;
  assign f1    = {hx[18:0], hx[31:19]};
  assign trial = {rem_q, quo_q[31]} - {1'b0, mod_q};

  assign job_ready_o   = (state_q == StIdle);
  assign res_valid_o   = (state_q == StOut);
  assign raw_hash_o    = h_q;
  assign remainder_o   = rem_q;
  assign signed_unit_o = h_q ^ SignFlip;
  assign last_o        = last_q;
  assign dbz_o         = dbz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            state_q  <= StW0a;
            h_q      <= seed_i;
            w_q      <= job_i.id[31:0];
            hi_q     <= job_i.id[63:32];
            mod_q    <= job_i.modulus;
            do_mod_q <= job_i.do_mod;
            last_q   <= job_i.last;
            dbz_q    <= job_i.do_mod && (job_i.modulus == '0);
          end
        end
        StW0a: begin
          w_q     <= wr;
          state_q <= StW0b;
        end
        StW0b: begin
          h_q     <= f1 * 32'd5 + MixAdd;
          w_q     <= hi_q;
          state_q <= StW1a;
        end
        StW1a: begin
          w_q     <= wr;
          state_q <= StW1b;
        end
        StW1b: begin
          // fold in the length and the first shift of the final mix
          h_q     <= (f1 * 32'd5 + MixAdd ^ 32'd8) ^
                     ((f1 * 32'd5 + MixAdd ^ 32'd8) >> 16);
          state_q <= StF1;
        end
        StF1: begin
          h_q     <= prod ^ (prod >> 13);
          state_q <= StF2;
        end
        StF2: begin
          h_q   <= prod ^ (prod >> 16);
          quo_q <= prod ^ (prod >> 16);
          rem_q <= '0;
          bit_q <= '0;
          if (do_mod_q && !dbz_q) begin
            state_q <= StDiv;
          end else begin
            state_q <= StOut;
          end
        end
        StDiv: begin
          // restoring division, one quotient bit per cycle
          if (!trial[WordW]) begin
            rem_q <= trial[WordW-1:0];
          end else begin
            rem_q <= {rem_q[WordW-2:0], quo_q[31]};
          end
          quo_q <= {quo_q[30:0], 1'b0};
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'd31) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire
